/* rtl/scps_pkg.sv */
package scps_pkg;

  localparam int unsigned MINUTES_12H  = 720;
  localparam int unsigned MIN_PER_HOUR = 60;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_LIMIT = 2'd2;

  localparam logic [TICKS_W-1:0] PULSE_LEN_RST  = 16'd100;
  localparam logic [TICKS_W-1:0] PULSE_GAP_RST  = 16'd100;
  localparam logic [POS_W-1:0]   LEAD_LIMIT_RST = 10'd30;

  typedef enum logic [2:0] {
    CMD_MS_TICK    = 3'd0,
    CMD_SEC_TICK   = 3'd1,
    CMD_COMM_START = 3'd2,
    CMD_COMM_STOP  = 3'd3,
    CMD_ADV_MINUTE = 3'd4,
    CMD_ADV_HOUR   = 3'd5,
    CMD_SHUTDOWN   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_PAUSE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] local_hour;
    logic [5:0] local_minute;
    logic [5:0] local_second;
  } req_t;

  typedef struct packed {
    logic             drive_level;
    logic [POS_W-1:0] hand_position;
    logic [POS_W-1:0] pending_steps;
    logic [1:0]       pulse_phase;
    logic             halted;
  } res_t;

endpackage

/* rtl/scps_chan_if.sv */
interface scps_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/scps_sync_calc.sv */
module scps_sync_calc (
  input  logic [4:0]                local_hour_i,
  input  logic [5:0]                local_minute_i,
  input  logic [scps_pkg::POS_W-1:0] position_i,
  input  logic                      in_flight_i,
  input  logic [scps_pkg::POS_W-1:0] lead_limit_i,
  output logic [scps_pkg::POS_W-1:0] pending_o
);
  import scps_pkg::*;

  localparam logic [10:0] M12  = 11'(MINUTES_12H);
  localparam logic [10:0] M24  = 11'(2 * MINUTES_12H);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MINUTES_12H - 1);

  logic [10:0]       total;
  logic [POS_W-1:0]  target;
  logic [POS_W-1:0]  eff;
  logic signed [10:0] diff;
  logic [10:0]       neg;
  logic [10:0]       lead_sum;
  logic [POS_W-1:0]  lead;

  // hour*60 = hour*64 - hour*4
  assign total = ({local_hour_i, 6'd0} - {4'd0, local_hour_i, 2'd0})
               + {5'd0, local_minute_i};

  always_comb begin
    if (total >= M24) begin
      target = POS_W'(total - M24);
    end else if (total >= M12) begin
      target = POS_W'(total - M12);
    end else begin
      target = total[POS_W-1:0];
    end
  end

  // a step in flight already counts as done
  assign eff = !in_flight_i ? position_i :
               (position_i == POS_MAX) ? '0 : position_i + 1'b1;

  assign diff     = $signed({1'b0, target}) - $signed({1'b0, eff});
  assign neg      = 11'(-diff);
  assign lead_sum = {1'b0, diff[POS_W-1:0]} + {1'b0, lead_limit_i};

  always_comb begin
    if (lead_sum >= M24) begin
      lead = POS_W'(lead_sum - M24);
    end else if (lead_sum >= M12) begin
      lead = POS_W'(lead_sum - M12);
    end else begin
      lead = lead_sum[POS_W-1:0];
    end
  end

  always_comb begin
    if (diff > 0) begin
      pending_o = (lead < lead_limit_i) ? '0 : diff[POS_W-1:0];
    end else if (neg > {1'b0, lead_limit_i}) begin
      // hands far ahead: go round the dial
      pending_o = POS_W'(M12 - neg);
    end else begin
      pending_o = '0;
    end
  end

endmodule

/* rtl/slave_clock_pulse_sync.sv */
// Channel  Dir  Payload                                         Handshake
// req_i    in   cmd, local_hour, local_minute, local_second     valid/ready
// res_o    out  drive_level, hand_position, pending_steps,      valid/ready
//               pulse_phase, halted
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i                 write strobe
//
// One result per request. An accepted request is held in the input register,
// then the state update and the result register load at the same edge;
// one request per cycle is sustained while the result side is not stalled.
// Throughput is set by the single state update path (sync calc + sequencer).
// rst_ni clears the clock state and the valid flags and loads the register defaults (100, 100, 30).
// A stalled result holds the input register; the input side stays open
// while the input register is empty or moving on in the same cycle.
module slave_clock_pulse_sync (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  scps_chan_if.sink                      req_i,
  scps_chan_if.source                    res_o,
  input  logic                           cfg_we_i,
  input  logic [scps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [scps_pkg::CFG_W-1:0]     cfg_data_i
);
  import scps_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MINUTES_12H - 1);

  // configuration
  logic [TICKS_W-1:0] pulse_len_q;
  logic [TICKS_W-1:0] pulse_gap_q;
  logic [POS_W-1:0]   lead_limit_q;

  // pipeline
  logic req_vld_q;
  req_t req_q;
  logic res_vld_q;
  res_t res_q;
  res_t res_d;
  logic advance;

  // clock state
  logic [POS_W-1:0]   position_q, position_d;
  logic [POS_W-1:0]   pending_q, pending_d;
  logic               comm_q, comm_d;
  logic               line_q, line_d;
  phase_e             phase_q, phase_d;
  logic [TICKS_W-1:0] timer_q, timer_d;
  logic               stopped_q, stopped_d;

  logic [TICKS_W-1:0] timer_inc;
  logic [POS_W-1:0]   sync_pending;

  // --- configuration writes ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_len_q  <= PULSE_LEN_RST;
      pulse_gap_q  <= PULSE_GAP_RST;
      lead_limit_q <= LEAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PULSE_LEN:  pulse_len_q  <= cfg_data_i;
        REG_PULSE_GAP:  pulse_gap_q  <= cfg_data_i;
        REG_LEAD_LIMIT: lead_limit_q <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // --- handshake ---
  // the held request moves on when the result register is free or drains
  assign advance     = req_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready = !req_vld_q || advance;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        req_vld_q <= 1'b1;
      end else if (advance) begin
        req_vld_q <= 1'b0;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // --- sync target ---
  scps_sync_calc u_sync (
    .local_hour_i   (req_q.local_hour),
    .local_minute_i (req_q.local_minute),
    .position_i     (position_q),
    .in_flight_i    (phase_q != PH_IDLE),
    .lead_limit_i   (lead_limit_q),
    .pending_o      (sync_pending)
  );

  assign timer_inc = timer_q + 1'b1;

  // --- state update for the held request ---
  always_comb begin
    position_d = position_q;
    pending_d  = pending_q;
    comm_d     = comm_q;
    line_d     = line_q;
    phase_d    = phase_q;
    timer_d    = timer_q;
    stopped_d  = stopped_q;

    if (!stopped_q) begin
      case (req_q.cmd)
        CMD_MS_TICK: begin
          case (phase_q)
            PH_PULSE: begin
              if (timer_inc >= pulse_len_q) begin
                phase_d = PH_PAUSE;
                timer_d = '0;
                line_d  = 1'b1;
              end else begin
                timer_d = timer_inc;
              end
            end
            PH_PAUSE: begin
              if (timer_inc >= pulse_gap_q) begin
                // step complete: hands have moved one minute
                phase_d    = PH_IDLE;
                timer_d    = '0;
                line_d     = 1'b0;
                position_d = (position_q == POS_MAX) ? '0 : position_q + 1'b1;
              end else begin
                timer_d = timer_inc;
              end
            end
            default: ;
          endcase
        end
        CMD_SEC_TICK: begin
          if (!comm_q) begin
            // a step in flight owns the line
            if (phase_q == PH_IDLE) begin
              line_d = ~line_q;
            end
            if (req_q.local_second == '0) begin
              pending_d = sync_pending;
            end
          end
        end
        CMD_COMM_START, CMD_COMM_STOP: begin
          comm_d    = (req_q.cmd == CMD_COMM_START);
          pending_d = '0;
        end
        CMD_ADV_MINUTE, CMD_ADV_HOUR: begin
          if (comm_q) begin
            pending_d = (req_q.cmd == CMD_ADV_MINUTE) ? POS_W'(1) : POS_W'(MIN_PER_HOUR);
          end
        end
        CMD_SHUTDOWN: begin
          // abandon any step in flight
          stopped_d = 1'b1;
          line_d    = 1'b0;
          phase_d   = PH_IDLE;
          timer_d   = '0;
        end
        default: ;
      endcase

      // launch the next step once the sequencer is free
      if (!stopped_d && phase_d == PH_IDLE && pending_d != '0) begin
        pending_d = pending_d - 1'b1;
        phase_d   = PH_PULSE;
        timer_d   = '0;
        line_d    = 1'b0;
      end
    end

    res_d.drive_level   = line_d;
    res_d.hand_position = position_d;
    res_d.pending_steps = pending_d;
    res_d.pulse_phase   = phase_d;
    res_d.halted        = stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      pending_q  <= '0;
      comm_q     <= 1'b0;
      line_q     <= 1'b0;
      phase_q    <= PH_IDLE;
      timer_q    <= '0;
      stopped_q  <= 1'b0;
    end else if (advance) begin
      position_q <= position_d;
      pending_q  <= pending_d;
      comm_q     <= comm_d;
      line_q     <= line_d;
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      stopped_q  <= stopped_d;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("halt flag cleared");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (phase_q == PH_IDLE && !line_q))
    else $error("sequencer active after shutdown");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_vld_q)
    else $error("state update without result");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (position_q != $past(position_q)) |-> $past(advance && phase_q == PH_PAUSE))
    else $error("hand position moved outside pause end");
`endif

endmodule
